// ===== sv/dnsae_pkg.sv =====
// shared types and constants for the dns answer address extractor
package dnsae_pkg;

   localparam int MAX_MESSAGE_BYTES_DEFAULT = 512;

   localparam int BYTE_W    = 8;
   localparam int ID_W      = 16;
   localparam int ADDR_W    = 32;
   localparam int WORD16_W  = 16;
   localparam int FIELD_W   = 4;

   // header byte positions
   localparam int POS_ID_HI   = 0;
   localparam int POS_ID_LO   = 1;
   localparam int POS_ANC_HI  = 6;
   localparam int POS_ANC_LO  = 7;
   localparam int POS_HDR_END = 11;

   localparam logic [BYTE_W-1:0]   POINTER_MASK = 8'hC0;
   localparam logic [FIELD_W-1:0]  QTAIL_LEN    = 4'd4;
   localparam logic [FIELD_W-1:0]  FIXED_LEN    = 4'd10;
   localparam logic [FIELD_W-1:0]  ADDR_LEN     = 4'd4;
   localparam logic [FIELD_W-1:0]  FIX_TYPE_HI  = 4'd0;
   localparam logic [FIELD_W-1:0]  FIX_TYPE_LO  = 4'd1;
   localparam logic [FIELD_W-1:0]  FIX_RDLEN_HI = 4'd8;
   localparam logic [FIELD_W-1:0]  FIX_RDLEN_LO = 4'd9;
   localparam logic [WORD16_W-1:0] TYPE_A       = 16'd1;
   localparam logic [WORD16_W-1:0] RDLEN_IPV4   = 16'd4;

   typedef enum logic [3:0] {
      PH_HEADER = 4'd0,
      PH_QNAME  = 4'd1,
      PH_QPTR   = 4'd2,
      PH_QTAIL  = 4'd3,
      PH_ANAME  = 4'd4,
      PH_APTR   = 4'd5,
      PH_AFIXED = 4'd6,
      PH_AADDR  = 4'd7,
      PH_ASKIP  = 4'd8,
      PH_DONE   = 4'd9
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic              last_byte;
   } item_type;

   typedef struct packed {
      phase_type phase;
      logic      count_zero;
      logic      count_over;
      logic      emit;
   } status_type;

endpackage

// ===== sv/dns_answer_address_extractor_top.sv =====
// top level of the dns answer address extractor
// usage:
// - req channel carries one byte of a dns response per word; req_tlast marks
//   the final byte of a message
// - rsp channel carries one ipv4 address per word for every a record whose
//   four address bytes all arrive; first received byte is the msb
// - csr channel writes the expected query id; write only while idle
// - messages whose id differs, or that end inside the 12-byte header, give
//   no words; bytes past MAX_MESSAGE_BYTES are dropped but req_tlast counts
// path: an accepted byte is held in the input register; the parser then reads it,
//   and any address word it completes is held in the result register for rsp
// throughput: one byte per cycle while no rsp word is held, set by the parser
//   update, combinational between the input register and the result register
// reset: synchronous; clears the parser state, the id register to zero and
//   both valid flags
// stall: a pending rsp word holds the parser; an empty input register takes
//   one more byte, then req_tready drops until rsp_tready frees the output
module dns_answer_address_extractor_top #(
   parameter int MAX_MESSAGE_BYTES = dnsae_pkg::MAX_MESSAGE_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] payload_byte
   input  logic        req_tlast,   // last_byte
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] ipv4_address
   // expected id write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // [15:0] expected_id
);

   logic [dnsae_pkg::ID_W-1:0] expected_id_ff;
   logic [dnsae_pkg::ID_W-1:0] expected_id_in;

   dnsae_pkg::item_type   req_item;
   dnsae_pkg::item_type   stage_item;
   logic                  stage_valid;
   logic                  stage_take;
   dnsae_pkg::status_type status;

   // id register, always ready
   assign csr_ready      = 1'b1;
   assign expected_id_in = (csr_valid && csr_ready) ? csr_data : expected_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff <= '0;
      end else begin
         expected_id_ff <= expected_id_in;
      end
   end

   assign req_item.payload_byte = req_tdata;
   assign req_item.last_byte    = req_tlast;

   dnsae_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (stage_valid),
      .out_take  (stage_take),
      .out_item  (stage_item)
   );

   dnsae_parser #(
      .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .expected_id (expected_id_ff),
      .item_valid  (stage_valid),
      .item        (stage_item),
      .item_take   (stage_take),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_addr    (rsp_tdata),
      .status      (status)
   );

   // message end brings the parser back to the header at byte zero
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (stage_take && stage_item.last_byte) |=>
         (status.phase == dnsae_pkg::PH_HEADER && status.count_zero))
      else $error("parser not cleared after last byte");

   // an address word only comes out of the address phase
   a_emit_phase: assert property (@(posedge clock) disable iff (reset)
      status.emit |-> (status.phase == dnsae_pkg::PH_AADDR && stage_take))
      else $error("address emitted outside address phase");

   // byte count saturates at the buffer size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      !status.count_over)
      else $error("byte count beyond buffer size");

   // input back-pressure only while a byte is parked and the parser is held
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (stage_valid && rsp_tvalid && !rsp_tready))
      else $error("input stalled without a held result");

endmodule

// ===== sv/dnsae_in_stage.sv =====
// input register stage holding one message byte for the parser
module dnsae_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  dnsae_pkg::item_type in_item,
   output logic                out_valid,
   input  logic                out_take,
   output dnsae_pkg::item_type out_item
);

   logic                valid_ff;
   logic                valid_in;
   dnsae_pkg::item_type item_ff;

   assign in_ready  = !valid_ff || out_take;
   assign valid_in  = (in_valid && in_ready) || (valid_ff && !out_take);
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

// ===== sv/dnsae_parser.sv =====
// per-byte dns response parser with registered address output
module dnsae_parser #(
   parameter int MAX_MESSAGE_BYTES = dnsae_pkg::MAX_MESSAGE_BYTES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [dnsae_pkg::ID_W-1:0]       expected_id,
   input  logic                             item_valid,
   input  dnsae_pkg::item_type              item,
   output logic                             item_take,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [dnsae_pkg::ADDR_W-1:0]     rsp_addr,
   output dnsae_pkg::status_type            status
);

   localparam int CW = $clog2(MAX_MESSAGE_BYTES + 1);

   dnsae_pkg::phase_type                phase_ff, phase_in;
   logic [CW-1:0]                       count_ff, count_in;
   logic [dnsae_pkg::BYTE_W-1:0]        id_hi_ff, id_hi_in;
   logic [dnsae_pkg::WORD16_W-1:0]      ans_total_ff, ans_total_in;
   logic [dnsae_pkg::WORD16_W-1:0]      ans_done_ff, ans_done_in;
   logic [dnsae_pkg::WORD16_W-1:0]      skip_ff, skip_in;
   logic [dnsae_pkg::FIELD_W-1:0]       fpos_ff, fpos_in;
   logic [dnsae_pkg::WORD16_W-1:0]      rtype_ff, rtype_in;
   logic [dnsae_pkg::WORD16_W-1:0]      dlen_ff, dlen_in;
   logic [dnsae_pkg::ADDR_W-1:0]        shift_ff, shift_in;
   logic                                ignore_ff, ignore_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [dnsae_pkg::ADDR_W-1:0]        rsp_addr_ff, rsp_addr_in;

   logic                                emit;
   logic [dnsae_pkg::BYTE_W-1:0]        b;
   logic [dnsae_pkg::WORD16_W-1:0]      done_inc;
   logic [dnsae_pkg::WORD16_W-1:0]      dlen_full;
   logic [dnsae_pkg::WORD16_W-1:0]      skip_dec;
   logic [dnsae_pkg::FIELD_W-1:0]       fpos_inc;
   dnsae_pkg::phase_type                after_answer;

   assign item_take = item_valid && (!rsp_valid_ff || rsp_ready);
   assign b         = item.payload_byte;
   assign done_inc  = ans_done_ff + 16'd1;
   assign after_answer = (done_inc >= ans_total_ff) ? dnsae_pkg::PH_DONE
                                                    : dnsae_pkg::PH_ANAME;
   assign dlen_full = {dlen_ff[15:8], b};
   assign skip_dec  = (skip_ff != '0) ? skip_ff - 16'd1 : skip_ff;
   assign fpos_inc  = fpos_ff + 4'd1;

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      id_hi_in     = id_hi_ff;
      ans_total_in = ans_total_ff;
      ans_done_in  = ans_done_ff;
      skip_in      = skip_ff;
      fpos_in      = fpos_ff;
      rtype_in     = rtype_ff;
      dlen_in      = dlen_ff;
      shift_in     = shift_ff;
      ignore_in    = ignore_ff;
      emit         = 1'b0;
      rsp_addr_in  = rsp_addr_ff;
      if (item_take) begin
         if (count_ff < CW'(MAX_MESSAGE_BYTES)) begin
            count_in = count_ff + CW'(1);
            if (!ignore_ff && phase_ff != dnsae_pkg::PH_DONE) begin
               case (phase_ff)
                  dnsae_pkg::PH_HEADER: begin
                     if (count_ff == CW'(dnsae_pkg::POS_ID_HI)) begin
                        id_hi_in = b;
                     end else if (count_ff == CW'(dnsae_pkg::POS_ID_LO)) begin
                        if ({id_hi_ff, b} != expected_id) begin
                           ignore_in = 1'b1;
                        end
                     end else if (count_ff == CW'(dnsae_pkg::POS_ANC_HI)) begin
                        ans_total_in = {b, 8'h00};
                     end else if (count_ff == CW'(dnsae_pkg::POS_ANC_LO)) begin
                        ans_total_in = {ans_total_ff[15:8], b};
                     end else if (count_ff == CW'(dnsae_pkg::POS_HDR_END)) begin
                        phase_in = dnsae_pkg::PH_QNAME;
                        skip_in  = '0;
                     end
                  end
                  dnsae_pkg::PH_QNAME, dnsae_pkg::PH_ANAME: begin
                     if (skip_ff != '0) begin
                        skip_in = skip_dec;
                     end else if ((b & dnsae_pkg::POINTER_MASK) == dnsae_pkg::POINTER_MASK)
                     begin
                        phase_in = (phase_ff == dnsae_pkg::PH_QNAME) ? dnsae_pkg::PH_QPTR
                                                                     : dnsae_pkg::PH_APTR;
                     end else if (b == '0) begin
                        // name ended with the root label
                        phase_in = (phase_ff == dnsae_pkg::PH_QNAME) ? dnsae_pkg::PH_QTAIL
                                                                     : dnsae_pkg::PH_AFIXED;
                        fpos_in  = '0;
                     end else begin
                        skip_in = {8'h00, b};
                     end
                  end
                  dnsae_pkg::PH_QPTR: begin
                     phase_in = dnsae_pkg::PH_QTAIL;
                     fpos_in  = '0;
                  end
                  dnsae_pkg::PH_APTR: begin
                     phase_in = dnsae_pkg::PH_AFIXED;
                     fpos_in  = '0;
                  end
                  dnsae_pkg::PH_QTAIL: begin
                     fpos_in = fpos_inc;
                     if (fpos_inc >= dnsae_pkg::QTAIL_LEN) begin
                        fpos_in  = '0;
                        skip_in  = '0;
                        phase_in = (ans_total_ff == '0) ? dnsae_pkg::PH_DONE
                                                        : dnsae_pkg::PH_ANAME;
                     end
                  end
                  dnsae_pkg::PH_AFIXED: begin
                     if (fpos_ff == dnsae_pkg::FIX_TYPE_HI) begin
                        rtype_in = {b, 8'h00};
                     end else if (fpos_ff == dnsae_pkg::FIX_TYPE_LO) begin
                        rtype_in = {rtype_ff[15:8], b};
                     end else if (fpos_ff == dnsae_pkg::FIX_RDLEN_HI) begin
                        dlen_in = {b, 8'h00};
                     end else if (fpos_ff == dnsae_pkg::FIX_RDLEN_LO) begin
                        dlen_in = dlen_full;
                     end
                     fpos_in = fpos_inc;
                     if (fpos_inc >= dnsae_pkg::FIXED_LEN) begin
                        fpos_in = '0;
                        skip_in = '0;
                        if (rtype_ff == dnsae_pkg::TYPE_A &&
                            dlen_full == dnsae_pkg::RDLEN_IPV4) begin
                           shift_in = '0;
                           phase_in = dnsae_pkg::PH_AADDR;
                        end else if (dlen_full == '0) begin
                           ans_done_in = done_inc;
                           phase_in    = after_answer;
                        end else begin
                           skip_in  = dlen_full;
                           phase_in = dnsae_pkg::PH_ASKIP;
                        end
                     end
                  end
                  dnsae_pkg::PH_AADDR: begin
                     shift_in = {shift_ff[23:0], b};
                     fpos_in  = fpos_inc;
                     if (fpos_inc >= dnsae_pkg::ADDR_LEN) begin
                        emit        = 1'b1;
                        rsp_addr_in = {shift_ff[23:0], b};
                        fpos_in     = '0;
                        ans_done_in = done_inc;
                        phase_in    = after_answer;
                     end
                  end
                  dnsae_pkg::PH_ASKIP: begin
                     skip_in = skip_dec;
                     if (skip_dec == '0) begin
                        ans_done_in = done_inc;
                        phase_in    = after_answer;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         if (item.last_byte) begin
            phase_in     = dnsae_pkg::PH_HEADER;
            count_in     = '0;
            id_hi_in     = '0;
            ans_total_in = '0;
            ans_done_in  = '0;
            skip_in      = '0;
            fpos_in      = '0;
            rtype_in     = '0;
            dlen_in      = '0;
            shift_in     = '0;
            ignore_in    = 1'b0;
         end
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= dnsae_pkg::PH_HEADER;
         count_ff     <= '0;
         id_hi_ff     <= '0;
         ans_total_ff <= '0;
         ans_done_ff  <= '0;
         skip_ff      <= '0;
         fpos_ff      <= '0;
         rtype_ff     <= '0;
         dlen_ff      <= '0;
         shift_ff     <= '0;
         ignore_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         id_hi_ff     <= id_hi_in;
         ans_total_ff <= ans_total_in;
         ans_done_ff  <= ans_done_in;
         skip_ff      <= skip_in;
         fpos_ff      <= fpos_in;
         rtype_ff     <= rtype_in;
         dlen_ff      <= dlen_in;
         shift_ff     <= shift_in;
         ignore_ff    <= ignore_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_addr_ff <= rsp_addr_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_addr  = rsp_addr_ff;

   assign status.phase      = phase_ff;
   assign status.count_zero = (count_ff == '0);
   assign status.count_over = (count_ff > CW'(MAX_MESSAGE_BYTES));
   assign status.emit       = emit;

endmodule
